FILE: rtl/deq_pkg.sv
// shared types and codes for the double-ended queue
package deq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_READ_IDX   = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BOUNDS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  localparam int unsigned OPCODE_W   = 3;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned POSITION_W = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OCC_W      = 9;

  typedef struct packed {
    op_t                   op;
    logic [POSITION_W-1:0] pos;
  } cmd_t;

endpackage

FILE: rtl/deq_front.sv
// front end: accepts items, decodes them and queues commands for the back end
module deq_front #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [deq_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [deq_pkg::VALUE_W-1:0]    in_value_in,
  input  logic [deq_pkg::POSITION_W-1:0] in_position,
  output logic                           cmd_valid,
  input  logic                           cmd_take,
  output deq_pkg::cmd_t                  cmd,
  output logic [DATA_WIDTH-1:0]          cmd_data
);

  deq_pkg::cmd_t                        q_cmd_r  [2];
  logic [DATA_WIDTH-1:0]                q_data_r [2];
  logic                                 wr_ptr_r;
  logic                                 rd_ptr_r;
  logic [1:0]                           q_cnt_r;
  logic                                 push;
  logic                                 pop;
  deq_pkg::cmd_t                        dec_cmd;
  logic [DATA_WIDTH+deq_pkg::VALUE_W-1:0] data_ext;

  assign in_stall = (q_cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = cmd_take && (q_cnt_r != 2'd0);

  // data kept to the storage width
  assign data_ext    = {{DATA_WIDTH{1'b0}}, in_value_in};
  assign dec_cmd.op  = deq_pkg::op_t'(in_opcode);
  assign dec_cmd.pos = in_position;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        q_cmd_r[wr_ptr_r]  <= dec_cmd;
        q_data_r[wr_ptr_r] <= data_ext[DATA_WIDTH-1:0];
        wr_ptr_r           <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        q_cnt_r <= q_cnt_r + 2'd1;
      end else if (pop && !push) begin
        q_cnt_r <= q_cnt_r - 2'd1;
      end
    end
  end

  assign cmd_valid = (q_cnt_r != 2'd0);
  assign cmd       = q_cmd_r[rd_ptr_r];
  assign cmd_data  = q_data_r[rd_ptr_r];

endmodule

FILE: rtl/deq_back.sv
// back end: ring buffer storage, pointer update and result register
module deq_back #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_take,
  input  deq_pkg::cmd_t                 cmd,
  input  logic [DATA_WIDTH-1:0]         cmd_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [deq_pkg::VALUE_W-1:0]   out_value_out,
  output logic [deq_pkg::STATUS_W-1:0]  out_status,
  output logic [deq_pkg::OCC_W-1:0]     out_occupancy
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned OW = (CW > deq_pkg::POSITION_W) ? CW : deq_pkg::POSITION_W;
  localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  typedef enum logic {S_IDLE, S_RESP} state_t;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  state_t                state_r;
  logic [AW-1:0]         head_r;
  logic [CW-1:0]         count_r;
  deq_pkg::status_t      pend_status_r;
  logic                  pend_rd_r;
  logic [DATA_WIDTH-1:0] rdata_r;
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_value_r;
  deq_pkg::status_t      out_status_r;
  logic [CW-1:0]         out_count_r;

  logic [AW-1:0]         head_nxt;
  logic [CW-1:0]         count_nxt;
  deq_pkg::status_t      st;
  logic                  we;
  logic                  re;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic                  empty;
  logic                  full;
  logic [AW-1:0]         head_dec;
  logic [AW-1:0]         last_off;
  logic [OW-1:0]         pos_ext;
  logic [OW-1:0]         cnt_ext;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                          input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, off};
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  assign cmd_take = (state_r == S_IDLE) && cmd_valid;
  assign empty    = (count_r == '0);
  assign full     = (count_r == DEPTH_C);
  assign head_dec = (head_r == '0) ? LAST_SLOT : head_r - AW'(1);
  assign last_off = AW'(count_r - CW'(1));
  assign pos_ext  = OW'(cmd.pos);
  assign cnt_ext  = OW'(count_r);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    st        = deq_pkg::ST_OK;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = head_r;
    raddr     = head_r;
    unique case (cmd.op)
      deq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          st = deq_pkg::ST_FULL;
        end else begin
          head_nxt  = head_dec;
          count_nxt = count_r + CW'(1);
          we        = 1'b1;
          waddr     = head_dec;
        end
      end
      deq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          st = deq_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
          we        = 1'b1;
          waddr     = slot(head_r, AW'(count_r));
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_PEEK_FRONT: begin
        if (empty) begin
          st = deq_pkg::ST_EMPTY;
        end else begin
          re    = 1'b1;
          raddr = head_r;
          if (cmd.op == deq_pkg::OP_POP_FRONT) begin
            head_nxt  = slot(head_r, AW'(1));
            count_nxt = count_r - CW'(1);
          end
        end
      end
      deq_pkg::OP_POP_BACK, deq_pkg::OP_PEEK_BACK: begin
        if (empty) begin
          st = deq_pkg::ST_EMPTY;
        end else begin
          re    = 1'b1;
          raddr = slot(head_r, last_off);
          if (cmd.op == deq_pkg::OP_POP_BACK) begin
            count_nxt = count_r - CW'(1);
          end
        end
      end
      deq_pkg::OP_READ_IDX: begin
        if (pos_ext >= cnt_ext) begin
          st = deq_pkg::ST_BOUNDS;
        end else begin
          re    = 1'b1;
          raddr = slot(head_r, pos_ext[AW-1:0]);
        end
      end
      deq_pkg::OP_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
        st = deq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_take && we) begin
      mem[waddr] <= cmd_data;
    end
    if (cmd_take && re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (out_valid_r && !out_stall) begin
            out_valid_r <= 1'b0;
          end
          if (cmd_take) begin
            head_r        <= head_nxt;
            count_r       <= count_nxt;
            pend_status_r <= st;
            pend_rd_r     <= re;
            state_r       <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= pend_rd_r ? rdata_r : '0;
            out_status_r <= pend_status_r;
            out_count_r  <= count_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  logic [DATA_WIDTH+deq_pkg::VALUE_W-1:0] value_ext;
  logic [CW+deq_pkg::OCC_W-1:0]           occ_ext;

  assign value_ext     = {{deq_pkg::VALUE_W{1'b0}}, out_value_r};
  assign occ_ext       = {{deq_pkg::OCC_W{1'b0}}, out_count_r};
  assign out_valid     = out_valid_r;
  assign out_value_out = value_ext[deq_pkg::VALUE_W-1:0];
  assign out_status    = out_status_r;
  assign out_occupancy = occ_ext[deq_pkg::OCC_W-1:0];

endmodule

FILE: rtl/double_ended_queue.sv
// double-ended queue on a ring buffer: decoding front end, queue, storage back end
// path of an item: front queue, then storage read, then result register
// the back end takes a new item only once the last one's result is loaded
// the front queue holds 2 items; input stalls once both are waiting
// reset: synchronous, active low; clears the head pointer, count and all valid flags
// storage is not cleared; only entries written by a push are ever read
module double_ended_queue #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [deq_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [deq_pkg::VALUE_W-1:0]    in_value_in,
  input  logic [deq_pkg::POSITION_W-1:0] in_position,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [deq_pkg::VALUE_W-1:0]    out_value_out,
  output logic [deq_pkg::STATUS_W-1:0]   out_status,
  output logic [deq_pkg::OCC_W-1:0]      out_occupancy
);

  logic                  cmd_valid;
  logic                  cmd_take;
  deq_pkg::cmd_t         cmd;
  logic [DATA_WIDTH-1:0] cmd_data;

  deq_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_value_in(in_value_in),
    .in_position(in_position),
    .cmd_valid  (cmd_valid),
    .cmd_take   (cmd_take),
    .cmd        (cmd),
    .cmd_data   (cmd_data)
  );

  deq_back #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd_take     (cmd_take),
    .cmd          (cmd),
    .cmd_data     (cmd_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value_out(out_value_out),
    .out_status   (out_status),
    .out_occupancy(out_occupancy)
  );

  localparam logic [deq_pkg::OCC_W-1:0] DEPTH_OCC = deq_pkg::OCC_W'(DEPTH);

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != deq_pkg::ST_OK) |-> out_value_out == '0)
    else $error("error result carries data");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == deq_pkg::ST_EMPTY) |-> out_occupancy == '0)
    else $error("empty status with nonzero occupancy");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == deq_pkg::ST_FULL) |-> out_occupancy == DEPTH_OCC)
    else $error("full status with occupancy below depth");

endmodule
